### sv/unique_key_stack_unit_defines.svh
// Assertion macros for the unique key stack unit.
`ifndef UNIQUE_KEY_STACK_UNIT_DEFINES_SVH
`define UNIQUE_KEY_STACK_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising clk outside reset.
`define UKSTK_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define UKSTK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/ukstk_pkg.sv
// Shared types and constants for the unique key stack unit.
package ukstk_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int KEY_W     = 32;
  localparam int KIND_W    = 2;
  localparam int DEPTH_W   = 7;

  localparam logic [KIND_W-1:0] KIND_PUSH   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_DUP   = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_POP,
    S_FINISH
  } state_t;

endpackage

### sv/ukstk_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ukstk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sv/unique_key_stack_unit.sv
// Unique key stack: LIFO of signed keys with duplicate rejection on push.
// Push and search scan the stack with one RAM read per held entry (stopping
// early on a match); pop reads the top entry; full push, empty pop and unused
// kinds go straight to the result. One item at a time; in_stall is high meanwhile.
// Throughput is set by the single RAM read port walked by the scan counter.
// Reset (rst, synchronous) empties the stack; RAM contents are not cleared.
`include "unique_key_stack_unit_defines.svh"

module unique_key_stack_unit #(
  parameter int DEPTH = ukstk_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ukstk_pkg::KIND_W-1:0]        kind,
  input  logic signed [ukstk_pkg::KEY_W-1:0]  key,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          status,
  output logic signed [ukstk_pkg::KEY_W-1:0]  popped_key,
  output logic                                found,
  output logic [ukstk_pkg::DEPTH_W-1:0]       depth
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  ukstk_pkg::state_t state, state_next;

  logic [ukstk_pkg::KIND_W-1:0] op_r;
  logic [ukstk_pkg::KEY_W-1:0]  key_r;
  logic                         hit;
  logic [CW-1:0]                cnt;
  logic                         rd_vld;
  logic [CW-1:0]                fill, fill_next;

  logic                         accept;
  logic                         match;
  logic                         issue;
  logic                         out_load;
  logic                         rd_en;
  logic [AW-1:0]                rd_addr;
  logic [ukstk_pkg::KEY_W-1:0]  rd_data;
  logic                         wr_en;

  ukstk_pkg::status_t           res_status;
  logic [ukstk_pkg::KEY_W-1:0]  res_popped;
  logic                         res_found;

  logic                         is_full;
  logic                         is_empty;

  assign in_stall = (state != ukstk_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign is_full  = (fill == CW'(DEPTH));
  assign is_empty = (fill == '0);
  assign match    = rd_vld && (rd_data == key_r);

  ukstk_ram #(
    .WIDTH (ukstk_pkg::KEY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill[AW-1:0]),
    .wr_data (key_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Datapath control and result formation
  always_comb begin
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    issue      = 1'b0;
    out_load   = 1'b0;
    res_status = ukstk_pkg::ST_OK;
    res_popped = '0;
    res_found  = 1'b0;
    fill_next  = fill;
    unique case (state)
      ukstk_pkg::S_IDLE: begin
      end
      ukstk_pkg::S_SCAN: begin
        // one read per cycle; compare happens in the cycle after its read
        issue   = !match && (cnt != fill);
        rd_en   = issue;
        rd_addr = cnt[AW-1:0];
      end
      ukstk_pkg::S_POP: begin
        rd_en   = 1'b1;
        rd_addr = AW'(fill - CW'(1));
      end
      ukstk_pkg::S_FINISH: begin
        out_load = !out_valid || !out_stall;
        unique case (op_r)
          ukstk_pkg::KIND_PUSH: begin
            if (is_full) begin
              res_status = ukstk_pkg::ST_FULL;
            end else if (hit) begin
              res_status = ukstk_pkg::ST_DUP;
              res_found  = 1'b1;
            end else begin
              wr_en     = out_load;
              fill_next = fill + CW'(1);
            end
          end
          ukstk_pkg::KIND_POP: begin
            if (is_empty) begin
              res_status = ukstk_pkg::ST_EMPTY;
            end else begin
              res_popped = rd_data;
              fill_next  = fill - CW'(1);
            end
          end
          ukstk_pkg::KIND_SEARCH: begin
            res_found = hit;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ukstk_pkg::S_IDLE: begin
        if (accept) begin
          unique case (kind)
            ukstk_pkg::KIND_PUSH: begin
              state_next = is_full ? ukstk_pkg::S_FINISH : ukstk_pkg::S_SCAN;
            end
            ukstk_pkg::KIND_POP: begin
              state_next = is_empty ? ukstk_pkg::S_FINISH : ukstk_pkg::S_POP;
            end
            ukstk_pkg::KIND_SEARCH: begin
              state_next = ukstk_pkg::S_SCAN;
            end
            default: begin
              state_next = ukstk_pkg::S_FINISH;
            end
          endcase
        end
      end
      ukstk_pkg::S_SCAN: begin
        if (!issue) begin
          state_next = ukstk_pkg::S_FINISH;
        end
      end
      ukstk_pkg::S_POP: begin
        state_next = ukstk_pkg::S_FINISH;
      end
      ukstk_pkg::S_FINISH: begin
        if (out_load) begin
          state_next = ukstk_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ukstk_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ukstk_pkg::S_IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
      rd_vld    <= 1'b0;
      hit       <= 1'b0;
      cnt       <= '0;
    end else begin
      state  <= state_next;
      rd_vld <= issue;
      if (accept) begin
        hit <= 1'b0;
        cnt <= '0;
      end else if (state == ukstk_pkg::S_SCAN) begin
        if (match) begin
          hit <= 1'b1;
        end
        if (issue) begin
          cnt <= cnt + CW'(1);
        end
      end
      if (out_load) begin
        fill      <= fill_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= kind;
      key_r <= key;
    end
    if (out_load) begin
      status     <= res_status;
      popped_key <= $signed(res_popped);
      found      <= res_found;
      depth      <= ukstk_pkg::DEPTH_W'(fill_next);
    end
  end

  `UKSTK_ASSERT_NOW(a_fill_bound, 1'b1, fill <= CW'(DEPTH), "fill count above DEPTH")
  `UKSTK_ASSERT_NOW(a_scan_bound, state == ukstk_pkg::S_SCAN, cnt <= fill, "scan past top")
  `UKSTK_ASSERT_NOW(a_out_src, $rose(out_valid), $past(state) == ukstk_pkg::S_FINISH, "result without finish")
  `UKSTK_ASSERT_NEXT(a_push_grow, out_load && op_r == ukstk_pkg::KIND_PUSH && res_status == ukstk_pkg::ST_OK, fill == $past(fill) + CW'(1), "push did not grow stack")

endmodule

### sim/testbench.sv
// Self-checking testbench for unique_key_stack_unit with a stack predictor and random traffic.
`timescale 1ns / 1ps

module testbench;
  import ukstk_pkg::*;

  localparam int STACK_DEPTH = DEPTH_DEF;
  localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;
  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

  typedef struct {
    status_t                   status;
    logic signed [KEY_W-1:0]   popped;
    logic                      found;
    logic [DEPTH_W-1:0]        depth;
  } stack_result_t;

  class stack_scoreboard;
    logic signed [KEY_W-1:0] held[STACK_DEPTH];
    int unsigned             fill;
    stack_result_t           pending[$];
    int                      errors;

    function new();
      fill = 0;
      errors = 0;
    endfunction

    function bit holds(logic signed [KEY_W-1:0] k);
      for (int i = 0; i < fill; i++) begin
        if (held[i] == k) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_request(logic [KIND_W-1:0] kind, logic signed [KEY_W-1:0] k);
      stack_result_t r;
      r.status = ST_OK;
      r.popped = '0;
      r.found  = 1'b0;
      case (kind)
        KIND_PUSH: begin
          if (fill >= STACK_DEPTH) begin
            r.status = ST_FULL;
          end else if (holds(k)) begin
            r.status = ST_DUP;
            r.found  = 1'b1;
          end else begin
            held[fill] = k;
            fill++;
          end
        end
        KIND_POP: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else begin
            fill--;
            r.popped = held[fill];
          end
        end
        KIND_SEARCH: r.found = holds(k);
        default: ;
      endcase
      r.depth = DEPTH_W'(fill);
      pending.push_back(r);
    endfunction

    function void check_response(logic [1:0] st, logic signed [KEY_W-1:0] pk, logic fd,
                                 logic [DEPTH_W-1:0] dp);
      stack_result_t exp_r;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result status=%0d key=%0d found=%0d depth=%0d",
                 $time, st, pk, fd, dp);
        return;
      end
      exp_r = pending.pop_front();
      if (st !== exp_r.status || pk !== exp_r.popped || fd !== exp_r.found ||
          dp !== exp_r.depth) begin
        errors++;
        $display("%0t: mismatch expected status=%0d key=%0d found=%0d depth=%0d,",
                 $time, exp_r.status, exp_r.popped, exp_r.found, exp_r.depth);
        $display("%0t:   got status=%0d key=%0d found=%0d depth=%0d",
                 $time, st, pk, fd, dp);
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [KIND_W-1:0]         kind = KIND_PUSH;
  logic signed [KEY_W-1:0]   key = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [1:0]                status;
  logic signed [KEY_W-1:0]   popped_key;
  logic                      found;
  logic [DEPTH_W-1:0]        depth;

  stack_scoreboard sb = new();
  int  items_sent = 0;
  int  burst_left = 0;
  bit  valid_on = 1'b0;
  int  stall_mode = 0;
  int  stall_left = 0;

  unique_key_stack_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .key        (key),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .popped_key (popped_key),
    .found      (found),
    .depth      (depth)
  );

  always #4 clk = ~clk;

  // receiver back-pressure: runs of free flow, light, heavy or solid stalls
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(5, 60);
      end
      stall_left--;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= $urandom_range(0, 1);
        default: out_stall <= (stall_left < 20);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_response(status, popped_key, found, depth);
  end

  task automatic send(input logic [KIND_W-1:0] k, input logic signed [KEY_W-1:0] v);
    in_valid <= 1'b1;
    kind     <= k;
    key      <= v;
    valid_on = 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_request(k, v);
    items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
      in_valid <= 1'b0;
      valid_on = 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    if (valid_on) begin
      in_valid <= 1'b0;
      valid_on = 1'b0;
    end
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [KEY_W-1:0] pool_key();
    case ($urandom_range(0, 7))
      0: return KEY_MIN;
      1: return KEY_MAX;
      2: return '0;
      3: return -1;
      default: return $urandom_range(0, 15);
    endcase
  endfunction

  function automatic logic signed [KEY_W-1:0] any_key();
    return $urandom_range(0, 1) ? pool_key() : $urandom;
  endfunction

  function automatic logic signed [KEY_W-1:0] search_key();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4 && sb.fill > 0) return sb.held[$urandom_range(0, sb.fill - 1)];
    return any_key();
  endfunction

  initial begin
    int unsigned r;
    bit paused;
    paused = 1'b0;
    burst_left = $urandom_range(1, 8);
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: empty cases, key extremes, duplicates, hits and misses, no-op kind
    send(KIND_POP, 32'sh1234_5678);
    send(KIND_SEARCH, '0);
    send(KIND_NOP, -1);
    send(KIND_PUSH, KEY_MIN);
    send(KIND_PUSH, KEY_MAX);
    send(KIND_PUSH, '0);
    send(KIND_PUSH, -1);
    send(KIND_PUSH, 32'sh5555_5555);
    send(KIND_PUSH, 32'shAAAA_AAAA);
    send(KIND_PUSH, KEY_MAX);
    send(KIND_PUSH, '0);
    send(KIND_SEARCH, KEY_MIN);
    send(KIND_SEARCH, 1);
    send(KIND_SEARCH, 32'shAAAA_AAAA);
    send(KIND_NOP, KEY_MAX);
    repeat (6) send(KIND_POP, $urandom);
    send(KIND_POP, '0);
    send(KIND_PUSH, 7);
    send(KIND_SEARCH, 7);
    send(KIND_POP, KEY_MIN);

    while (items_sent < 750) begin
      if (!paused && items_sent >= 375) begin
        wait_for_results();
        paused = 1'b1;
      end
      r = $urandom_range(0, 9);
      if (r < 4) begin
        // fill to the top, then bang on the full stack
        while (sb.fill < STACK_DEPTH) begin
          r = $urandom_range(0, 9);
          if (r == 0) send(KIND_SEARCH, search_key());
          else if (r == 1) send(KIND_PUSH, pool_key());
          else send(KIND_PUSH, $urandom);
        end
        repeat ($urandom_range(1, 4)) send(KIND_PUSH, any_key());
      end else if (r < 7) begin
        while (sb.fill > 0) begin
          if ($urandom_range(0, 7) == 0) send(KIND_SEARCH, search_key());
          else send(KIND_POP, $urandom);
        end
        repeat ($urandom_range(1, 3)) send(KIND_POP, $urandom);
      end else begin
        repeat ($urandom_range(10, 40)) begin
          r = $urandom_range(0, 19);
          if (r < 8) send(KIND_PUSH, any_key());
          else if (r < 14) send(KIND_POP, $urandom);
          else if (r < 19) send(KIND_SEARCH, search_key());
          else send(KIND_NOP, $urandom);
        end
      end
    end

    wait_for_results();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[unique_key_stack_unit] OK");
    end else begin
      $display("[unique_key_stack_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("[unique_key_stack_unit] ERROR");
    $finish;
  end

endmodule
